// ----- rtl/amd_pkg.sv -----
package amd_pkg;

   localparam int AccelWidth    = 17;
   localparam int DiffWidth     = AccelWidth + 1;
   localparam int CountWidth    = 13;
   localparam int ThreshWidth   = 11;
   localparam int FlagWidth     = 8;
   localparam int SelWidth      = 4;
   localparam int RangeWidth    = 2;
   localparam int AxisCount     = 3;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 13;

   // smallest full scale (2 g) in counts
   localparam int BaseLimit = 4096;

   localparam logic [CsrIndexWidth-1:0] CSR_MOTION_ENABLE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_AXIS_ENABLE   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DURATION      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_THRESHOLD     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_OUTPUT_SELECT = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_ACCEL_RANGE   = 3'd5;

   localparam logic                   MOTION_ENABLE_RESET = 1'b0;
   localparam logic [AxisCount-1:0]   AXIS_ENABLE_RESET   = 3'b111;
   localparam logic [CountWidth-1:0]  DURATION_RESET      = 13'd5;
   localparam logic [ThreshWidth-1:0] THRESHOLD_RESET     = 11'd170;
   localparam logic [SelWidth-1:0]    OUTPUT_SELECT_RESET = 4'd7;
   localparam logic [RangeWidth-1:0]  ACCEL_RANGE_RESET   = 2'd2;

   localparam logic CMD_EVALUATE = 1'b0;
   localparam logic CMD_REARM    = 1'b1;

   typedef struct packed {
      logic [ThreshWidth-1:0] threshold;
      logic [RangeWidth-1:0]  accel_range;
   } amd_axis_cfg_type;

endpackage

// ----- rtl/amd_axis.sv -----
module amd_axis (
   input  amd_pkg::amd_axis_cfg_type               cfg,
   input  logic signed [amd_pkg::AccelWidth-1:0]   sample,
   input  logic signed [amd_pkg::AccelWidth-1:0]   reference,
   output logic signed [amd_pkg::AccelWidth-1:0]   clamped,
   output logic                                    exceeds
);
   import amd_pkg::*;

   logic signed [DiffWidth-1:0] limit;
   logic signed [DiffWidth-1:0] sample_ext;
   logic signed [DiffWidth-1:0] clamped_ext;
   logic signed [DiffWidth-1:0] diff;
   logic        [DiffWidth-1:0] magnitude;

   always_comb begin
      limit      = DiffWidth'(BaseLimit) << cfg.accel_range;
      sample_ext = DiffWidth'(sample);
      if (sample_ext > limit) begin
         clamped_ext = limit;
      end else if (sample_ext < -limit) begin
         clamped_ext = -limit;
      end else begin
         clamped_ext = sample_ext;
      end
      // full scale is at most 16 g, so the clamped value fits the sample width
      clamped   = clamped_ext[AccelWidth-1:0];
      diff      = clamped_ext - DiffWidth'(reference);
      magnitude = diff[DiffWidth-1] ? DiffWidth'(-diff) : DiffWidth'(diff);
      exceeds   = magnitude > DiffWidth'(cfg.threshold);
   end

endmodule

// ----- rtl/any_motion_detector.sv -----
// Any-motion slope detector. Each request carries a command and a three-axis
// sample in 1/2048 g; every request gives exactly one response. A request is
// taken into an input register, and from there the clamp, the slope compare
// against the stored reference and the duration counter update run in one
// pass into the response register; while the response is not stalled, one
// request can be accepted every cycle. Configuration is written through the
// csr_ port, which is always ready; it should be written only while no
// request is in flight.
module any_motion_detector (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [amd_pkg::AccelWidth-1:0] req_accel_x,
   input  logic signed [amd_pkg::AccelWidth-1:0] req_accel_y,
   input  logic signed [amd_pkg::AccelWidth-1:0] req_accel_z,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [amd_pkg::FlagWidth-1:0]         rsp_motion_flags,
   output logic                                  rsp_detected,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [amd_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [amd_pkg::CsrDataWidth-1:0]      csr_data
);
   import amd_pkg::*;

   // configuration
   logic                   motion_enable_ff;
   logic [AxisCount-1:0]   axis_enable_ff;
   logic [CountWidth-1:0]  duration_ff;
   logic [ThreshWidth-1:0] threshold_ff;
   logic [SelWidth-1:0]    output_select_ff;
   logic [RangeWidth-1:0]  accel_range_ff;

   // input register
   logic                          in_valid_ff;
   logic                          in_cmd_ff;
   logic signed [AccelWidth-1:0]  in_sample_ff [AxisCount];

   // detector state
   logic signed [AccelWidth-1:0]  ref_ff [AxisCount];
   logic signed [AccelWidth-1:0]  ref_in [AxisCount];
   logic [CountWidth-1:0]         count_ff;
   logic [CountWidth-1:0]         count_in;

   // response register
   logic                  rsp_valid_ff;
   logic [FlagWidth-1:0]  rsp_flags_ff;
   logic [FlagWidth-1:0]  rsp_flags_in;
   logic                  rsp_detected_ff;
   logic                  rsp_detected_in;

   amd_axis_cfg_type             axis_cfg;
   logic signed [AccelWidth-1:0] clamped [AxisCount];
   logic [AxisCount-1:0]         exceeds;
   logic                         advance;
   logic                         execute;
   logic                         trigger;
   logic [CountWidth-1:0]        target;
   logic [CountWidth:0]          count_plus;
   logic [SelWidth-1:0]          sel_minus;
   logic [FlagWidth-1:0]         flag_onehot;

   assign axis_cfg.threshold   = threshold_ff;
   assign axis_cfg.accel_range = accel_range_ff;

   for (genvar a = 0; a < AxisCount; a++) begin : g_axis
      amd_axis u_axis (
         .cfg       (axis_cfg),
         .sample    (in_sample_ff[a]),
         .reference (ref_ff[a]),
         .clamped   (clamped[a]),
         .exceeds   (exceeds[a])
      );
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign execute   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motion_flags = rsp_flags_ff;
   assign rsp_detected     = rsp_detected_ff;

   always_comb begin
      trigger     = |(axis_enable_ff & exceeds);
      target      = (duration_ff == '0) ? CountWidth'(1) : duration_ff;
      count_plus  = {1'b0, count_ff} + (CountWidth + 1)'(1);
      sel_minus   = output_select_ff - SelWidth'(1);
      flag_onehot = ((output_select_ff != '0) && (output_select_ff <= SelWidth'(FlagWidth)))
                    ? (FlagWidth'(1) << sel_minus[2:0]) : '0;

      ref_in          = ref_ff;
      count_in        = count_ff;
      rsp_flags_in    = '0;
      rsp_detected_in = 1'b0;

      if (in_cmd_ff == CMD_REARM) begin
         ref_in   = clamped;
         count_in = '0;
      end else if (motion_enable_ff) begin
         if (!trigger) begin
            count_in = '0;
         end else if (count_plus >= {1'b0, target}) begin
            count_in        = target;
            rsp_detected_in = 1'b1;
            rsp_flags_in    = flag_onehot;
            ref_in          = clamped;
         end else begin
            count_in = count_plus[CountWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_enable_ff <= MOTION_ENABLE_RESET;
         axis_enable_ff   <= AXIS_ENABLE_RESET;
         duration_ff      <= DURATION_RESET;
         threshold_ff     <= THRESHOLD_RESET;
         output_select_ff <= OUTPUT_SELECT_RESET;
         accel_range_ff   <= ACCEL_RANGE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOTION_ENABLE: motion_enable_ff <= csr_data[0];
            CSR_AXIS_ENABLE:   axis_enable_ff   <= csr_data[AxisCount-1:0];
            CSR_DURATION:      duration_ff      <= csr_data[CountWidth-1:0];
            CSR_THRESHOLD:     threshold_ff     <= csr_data[ThreshWidth-1:0];
            CSR_OUTPUT_SELECT: output_select_ff <= csr_data[SelWidth-1:0];
            CSR_ACCEL_RANGE:   accel_range_ff   <= csr_data[RangeWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cmd_ff       <= req_cmd;
         in_sample_ff[0] <= req_accel_x;
         in_sample_ff[1] <= req_accel_y;
         in_sample_ff[2] <= req_accel_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AxisCount; a++) begin
            ref_ff[a] <= '0;
         end
         count_ff <= '0;
      end else if (execute) begin
         ref_ff   <= ref_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (execute) begin
         rsp_flags_ff    <= rsp_flags_in;
         rsp_detected_ff <= rsp_detected_in;
      end
   end

   // a detection always leaves a nonzero count behind
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_detected_ff) |-> (count_ff != '0))
      else $error("detection without a saturated count");

   // a flag is only raised together with detection
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_flags_ff != '0)) |-> (rsp_detected_ff && $onehot(rsp_flags_ff)))
      else $error("flag raised without detection or not one-hot");

   // a request held in the input register is not lost while the response stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_cmd_ff)))
      else $error("stalled request dropped");

   // state moves only when a request is executed
   assert property (@(posedge clock) disable iff (reset)
      !execute |=> $stable(count_ff))
      else $error("count changed without a request");

endmodule
